### hw/rtl/ccm_pkg.sv
// Shared types and constants for the channel completion monitor.
`default_nettype none

package ccm_pkg;

    localparam int CMD_W     = 2;
    localparam int CHAN_W    = 4;
    localparam int FENCE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 16;
    localparam int LIMIT_W   = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_SUBMIT = 2'd1,
        CMD_POLL   = 2'd2,
        CMD_RETIRE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HANDLED  = 2'd0,
        STAT_INACTIVE = 2'd1,
        STAT_SKIPPED  = 2'd2
    } status_t;

endpackage

`default_nettype wire

### hw/rtl/ccm_req_if.sv
// Command channel: valid/ready handshake carrying one command word.
`default_nettype none

interface ccm_req_if;
    logic                         valid;
    logic                         ready;
    logic [ccm_pkg::CMD_W-1:0]    cmd;
    logic [ccm_pkg::CHAN_W-1:0]   channel;
    logic [ccm_pkg::FENCE_W-1:0]  count_target;
    logic [ccm_pkg::FENCE_W-1:0]  counter_value;

    modport source (output valid, cmd, channel, count_target, counter_value, input ready);
    modport sink   (input valid, cmd, channel, count_target, counter_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/ccm_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
`default_nettype none

interface ccm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          completed;
    logic                          abuse_detected;
    logic [ccm_pkg::CHAN_W-1:0]    channel_out;
    logic [ccm_pkg::STATUS_W-1:0]  status;

    modport source (output valid, completed, abuse_detected, channel_out, status, input ready);
    modport sink   (input valid, completed, abuse_detected, channel_out, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/channel_completion_monitor_unit.sv
// Channel completion monitor: top level with per-channel fence tracking.
//
// Usage:
//   req  - command words (tick start, submit, poll, retire) with channel,
//          fence target and current fence counter.
//   rsp  - exactly one result word per command: completed, abuse_detected,
//          echoed channel and status.
//   cfg_we / cfg_wdata - write of abuse_limit (0 turns abuse checking off);
//          write only while no command is in flight.
// Path: a word accepted on req passes the input register and then the result
//   register before it shows on rsp.
//   Throughput: one word per cycle while rsp takes its words; the whole update
//   of a command (fence compare, count step, count reset of the other channels)
//   sits between the input register and the result register.
// Fence targets live in a small memory read at acceptance; a submit still in
//   the input register is forwarded to a following word on the same channel.
// Reset: all channels inactive, counts zero, abort flag clear, limit zero.
//   Target memory is not cleared; its contents are used only for active channels.
// Stall: if rsp is held off, the result register and then the input register
//   hold their words and req.ready drops; nothing is lost or repeated.
`default_nettype none

module channel_completion_monitor_unit #(
    parameter int CHANNELS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ccm_req_if.sink                          req,
    ccm_rsp_if.source                        rsp,
    input  wire logic                        cfg_we,
    input  wire logic [ccm_pkg::LIMIT_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(CHANNELS);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [ccm_pkg::LIMIT_W-1:0] abuse_limit_reg;
    logic [CHANNELS-1:0]         active_reg;
    logic [CHANNELS-1:0]         active_next;
    logic [ccm_pkg::COUNT_W-1:0] count_reg  [CHANNELS];
    logic [ccm_pkg::COUNT_W-1:0] count_next [CHANNELS];
    logic                        abort_reg;
    logic                        abort_next;

    // fence targets: one write port, one registered read port
    logic [ccm_pkg::FENCE_W-1:0] target_mem [CHANNELS];

    // input stage
    logic                        s1_valid_reg;
    logic [ccm_pkg::CMD_W-1:0]   s1_cmd_reg;
    logic [ccm_pkg::CHAN_W-1:0]  s1_chan_reg;
    logic [ccm_pkg::FENCE_W-1:0] s1_target_reg;
    logic [ccm_pkg::FENCE_W-1:0] s1_value_reg;
    logic [ccm_pkg::FENCE_W-1:0] tgt_rd_reg;

    // result stage
    logic                         out_valid_reg;
    logic                         out_completed_reg;
    logic                         out_abuse_reg;
    logic [ccm_pkg::CHAN_W-1:0]   out_chan_reg;
    logic [ccm_pkg::STATUS_W-1:0] out_status_reg;

    // control
    logic                 s1_adv;
    logic                 in_acc;
    logic                 commit;
    ccm_pkg::cmd_t        s1_cmd;
    logic                 ch_ok;
    logic [IDX_W-1:0]     s1_idx;
    logic [IDX_W-1:0]     in_idx;
    logic                 cur_active;
    logic [ccm_pkg::COUNT_W-1:0] cur_count;
    logic                 tgt_we;
    logic                 fwd;
    logic                 res_completed;
    logic                 res_abuse;
    ccm_pkg::status_t     res_status;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign in_acc    = req.valid && req.ready;
    assign commit    = s1_valid_reg && s1_adv;

    assign s1_cmd = ccm_pkg::cmd_t'(s1_cmd_reg);
    assign ch_ok  = (32'(s1_chan_reg) < 32'(CHANNELS));
    assign s1_idx = IDX_W'(s1_chan_reg);
    assign in_idx = IDX_W'(req.channel);

    // selected channel's flags (ch_ok gates any use)
    always_comb
    begin
        cur_active = 1'b0;
        cur_count  = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (IDX_W'(c) == s1_idx)
            begin
                cur_active = active_reg[c];
                cur_count  = count_reg[c];
            end
        end
    end

    // ---------------------------------------------------------------
    // Command evaluation
    // ---------------------------------------------------------------
    always_comb
    begin
        active_next   = active_reg;
        count_next    = count_reg;
        abort_next    = abort_reg;
        tgt_we        = 1'b0;
        res_completed = 1'b0;
        res_abuse     = 1'b0;
        res_status    = ccm_pkg::STAT_HANDLED;

        if (s1_cmd == ccm_pkg::CMD_TICK)
        begin
            abort_next = 1'b0;
        end
        else if (!ch_ok)
        begin
            res_status = ccm_pkg::STAT_INACTIVE;
        end
        else
        begin
            case (s1_cmd)
                ccm_pkg::CMD_SUBMIT:
                begin
                    active_next[s1_idx] = 1'b1;
                    count_next[s1_idx]  = ccm_pkg::COUNT_ONE;
                    tgt_we              = 1'b1;
                end
                ccm_pkg::CMD_POLL:
                begin
                    if (abort_reg)
                    begin
                        res_status = ccm_pkg::STAT_SKIPPED;
                    end
                    else if (!cur_active)
                    begin
                        res_status = ccm_pkg::STAT_INACTIVE;
                    end
                    else if (s1_value_reg >= tgt_rd_reg)
                    begin
                        active_next[s1_idx] = 1'b0;
                        count_next[s1_idx]  = '0;
                        res_completed       = 1'b1;
                    end
                    else if (abuse_limit_reg != '0 && cur_count != '0)
                    begin
                        if (cur_count != ccm_pkg::COUNT_MAX)
                        begin
                            count_next[s1_idx] = cur_count + ccm_pkg::COUNT_ONE;
                        end
                        if (cur_count > abuse_limit_reg)
                        begin
                            res_abuse  = 1'b1;
                            abort_next = 1'b1;
                            for (int c = 0; c < CHANNELS; c++)
                            begin
                                if (IDX_W'(c) != s1_idx && active_reg[c] &&
                                    count_reg[c] != '0)
                                begin
                                    count_next[c] = ccm_pkg::COUNT_ONE;
                                end
                            end
                        end
                    end
                end
                ccm_pkg::CMD_RETIRE:
                begin
                    if (cur_active)
                    begin
                        active_next[s1_idx] = 1'b0;
                        count_next[s1_idx]  = '0;
                        res_completed       = 1'b1;
                    end
                    else
                    begin
                        res_status = ccm_pkg::STAT_INACTIVE;
                    end
                end
                default:
                begin
                    res_status = ccm_pkg::STAT_HANDLED;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abuse_limit_reg <= '0;
            active_reg      <= '0;
            abort_reg       <= 1'b0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                abuse_limit_reg <= cfg_wdata;
            end
            if (commit)
            begin
                active_reg <= active_next;
                abort_reg  <= abort_next;
                count_reg  <= count_next;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers and target memory
    // ---------------------------------------------------------------
    // a submit committing now is newer than the memory contents
    assign fwd = commit && tgt_we && (s1_chan_reg == req.channel);

    always_ff @(posedge clk)
    begin
        if (commit && tgt_we)
        begin
            target_mem[s1_idx] <= s1_target_reg;
        end
        if (in_acc)
        begin
            s1_cmd_reg    <= req.cmd;
            s1_chan_reg   <= req.channel;
            s1_target_reg <= req.count_target;
            s1_value_reg  <= req.counter_value;
            tgt_rd_reg    <= fwd ? s1_target_reg : target_mem[in_idx];
        end
        if (commit)
        begin
            out_completed_reg <= res_completed;
            out_abuse_reg     <= res_abuse;
            out_chan_reg      <= s1_chan_reg;
            out_status_reg    <= res_status;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.completed      = out_completed_reg;
    assign rsp.abuse_detected = out_abuse_reg;
    assign rsp.channel_out    = out_chan_reg;
    assign rsp.status         = out_status_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic [CHANNELS-1:0] cnt_nz;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            cnt_nz[c] = (count_reg[c] != '0);
        end
    end

    // a channel holds a nonzero count exactly while it is active
    assert property (@(posedge clk) disable iff (!rst_n) active_reg == cnt_nz)
        else $error("period count out of step with channel activity");

    // an abuse result leaves the tick aborted
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && res_abuse |=> abort_reg)
        else $error("abuse flagged without aborting the tick");

    // skipped polls only happen while the tick is aborted
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && res_status == ccm_pkg::STAT_SKIPPED |-> abort_reg)
        else $error("poll skipped outside an aborted tick");

    // a word never both completes and flags abuse
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_completed_reg && out_abuse_reg))
        else $error("completion and abuse reported together");

endmodule

`default_nettype wire
